### rtl/tcse_pkg.sv
// Shared types and constants for the text console scrollback engine.
// No dependencies.
package tcse_pkg;

   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_RETURN    = 8'h0D;
   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   localparam logic [7:0] COLS_RESET = 8'd80;
   localparam logic [6:0] ROWS_RESET = 7'd25;

   typedef enum logic [1:0] {
      CMD_PUT   = 2'd0,
      CMD_VIEW  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_READ  = 2'd3
   } cmd_code_type;

   typedef enum logic [0:0] {
      REG_COLUMNS = 1'b0,
      REG_ROWS    = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      SRC_SPACE  = 2'd0,
      SRC_HIST   = 2'd1,
      SRC_SCREEN = 2'd2
   } src_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic fill;
      logic save;
      logic move;
      logic emit;
   } tcse_cmd_type;

   typedef struct packed {
      logic is_put;
      logic fill_needed;
      logic fill_last;
      logic line_over;
      logic save_last;
      logic move_last;
      logic out_free;
   } tcse_stat_type;

endpackage

### rtl/tcse_ctrl.sv
// Controller state machine for the console engine.
// Depends on tcse_pkg (command and status structs).
module tcse_ctrl import tcse_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  tcse_stat_type stat,
   output tcse_cmd_type  cmd
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_EXEC  = 7'b0000010,
      ST_FILL  = 7'b0000100,
      ST_CHECK = 7'b0001000,
      ST_SAVE  = 7'b0010000,
      ST_MOVE  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_tvalid;
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (!stat.is_put) state_in = ST_DONE;
            else if (stat.fill_needed) state_in = ST_FILL;
            else state_in = ST_CHECK;
         end
         ST_FILL: begin
            cmd.fill = 1'b1;
            if (stat.fill_last) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = stat.line_over ? ST_SAVE : ST_DONE;
         end
         ST_SAVE: begin
            cmd.save = 1'b1;
            if (stat.save_last) state_in = ST_MOVE;
         end
         ST_MOVE: begin
            cmd.move = 1'b1;
            if (stat.move_last) state_in = ST_CHECK;
         end
         ST_DONE: begin
            cmd.emit = stat.out_free;
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_EXEC))
      else $error("accepted transaction did not start execution");

   a_emit_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (state_ff == ST_IDLE))
      else $error("no return to idle after result");

   a_fill_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> ($past(state_ff) == ST_EXEC || $past(state_ff) == ST_FILL))
      else $error("row fill entered from wrong state");

endmodule

### rtl/tcse_datapath.sv
// Datapath: cursor, ring pointers, screen and scrollback memories, result register.
// Depends on tcse_pkg; driven by tcse_ctrl commands.
module tcse_datapath import tcse_pkg::*; #(
   parameter int MAX_COLS     = 128,
   parameter int MAX_ROWS     = 64,
   parameter int HISTORY_ROWS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  tcse_cmd_type       cmd,
   output tcse_stat_type      stat,
   input  logic               csr_wr,
   input  logic [0:0]         csr_index,
   input  logic [7:0]         csr_data,
   input  logic [1:0]         in_command,
   input  logic [7:0]         in_char_code,
   input  logic signed [9:0]  in_scroll_delta,
   input  logic [6:0]         in_read_col,
   input  logic [5:0]         in_read_row,
   input  logic               rsp_tready,
   output logic               rsp_tvalid,
   output logic [7:0]         out_cell_char,
   output logic [6:0]         out_cursor_col,
   output logic [5:0]         out_cursor_row,
   output logic [8:0]         out_view_offset,
   output logic [8:0]         out_history_rows_held,
   output logic               out_scrolled
);

   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int CC_W       = $clog2(MAX_COLS + 1);
   localparam int RC_W       = $clog2(MAX_ROWS + 1);
   localparam int HEAD_W     = $clog2(HISTORY_ROWS);
   localparam int CNT_W      = $clog2(HISTORY_ROWS + 1);
   localparam int VROWS      = 1 << ROW_W;
   localparam int SCR_DEPTH  = VROWS << COL_W;
   localparam int HIST_DEPTH = HISTORY_ROWS << COL_W;
   localparam int SW         = CNT_W + 12;
   localparam int PW         = CNT_W + 8;
   localparam int CW         = 16;

   logic [7:0]         cols_cfg_ff;
   logic [6:0]         rows_cfg_ff;
   cmd_code_type       cmd_ff;
   logic [7:0]         ch_ff;
   logic signed [9:0]  delta_ff;
   logic [6:0]         rcol_ff;
   logic [5:0]         rrow_ff;
   logic [COL_W-1:0]   cur_col_ff;
   logic [ROW_W:0]     cur_line_ff;
   logic [HEAD_W-1:0]  head_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   view_ff;
   logic [VROWS-1:0]   row_valid_ff;
   logic               scrolled_ff;
   logic [COL_W:0]     cnt_ff;
   logic               pend_ff;
   logic [COL_W-1:0]   wcol_ff;
   logic [ROW_W-1:0]   mrow_ff;
   logic [ROW_W-1:0]   frow_ff;
   logic [COL_W-1:0]   fcol_ff;
   logic [7:0]         fch_ff;
   logic [7:0]         scr_rd_ff;
   logic               scr_rd_ok_ff;
   logic [7:0]         hist_rd_ff;
   src_type            rd_src_ff;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_cell_ff;
   logic [6:0]         rsp_col_ff;
   logic [5:0]         rsp_row_ff;
   logic [8:0]         rsp_view_ff;
   logic [8:0]         rsp_hist_ff;
   logic               rsp_scr_ff;

   logic [7:0] screen_mem [0:SCR_DEPTH-1];
   logic [7:0] hist_mem   [0:HIST_DEPTH-1];

   logic [CC_W-1:0]    cols_eff;
   logic [RC_W-1:0]    rows_eff;
   logic [COL_W-1:0]   n_col;
   logic [ROW_W:0]     n_line;
   logic [COL_W:0]     c_inc;
   logic               w_en;
   logic               w_ok;
   logic [COL_W-1:0]   w_col;
   logic [ROW_W-1:0]   w_row;
   logic [7:0]         w_ch;
   logic               rd_out;
   logic [PW-1:0]      pos;
   logic [PW-1:0]      slot_r;
   logic [PW-1:0]      spos;
   logic               in_hist;
   logic               s_far;
   logic signed [SW-1:0] vsum;
   logic [CNT_W-1:0]   view_clamp;
   logic [CNT_W:0]     slot_s;
   logic [HEAD_W-1:0]  save_slot;
   logic [HEAD_W:0]    head_inc;
   logic [CNT_W-1:0]   count_new;
   logic [HEAD_W-1:0]  head_new;
   logic               sweep_last;
   logic               move_last;
   logic               nxt_ok;
   logic [ROW_W-1:0]   mrow_nxt;
   logic               sweep_on;
   logic               scr_re;
   logic [ROW_W-1:0]   scr_rrow;
   logic [COL_W-1:0]   scr_rcol;
   logic               scr_we;
   logic [ROW_W-1:0]   scr_wrow;
   logic [COL_W-1:0]   scr_wcol;
   logic [7:0]         scr_wdata;
   logic               is_read;
   logic               is_put;
   logic [7:0]         cell_val;

   always_comb begin
      if (cols_cfg_ff == '0) cols_eff = CC_W'(1);
      else if (CW'(cols_cfg_ff) > CW'(MAX_COLS)) cols_eff = CC_W'(MAX_COLS);
      else cols_eff = CC_W'(cols_cfg_ff);
      if (rows_cfg_ff == '0) rows_eff = RC_W'(1);
      else if (CW'(rows_cfg_ff) > CW'(MAX_ROWS)) rows_eff = RC_W'(MAX_ROWS);
      else rows_eff = RC_W'(rows_cfg_ff);
   end

   assign is_read = (cmd_ff == CMD_READ);
   assign is_put  = (cmd_ff == CMD_PUT);

   // put char: next cursor and the one cell, if any, that it touches
   always_comb begin
      n_col = cur_col_ff;
      n_line = cur_line_ff;
      w_en  = 1'b0;
      w_col = cur_col_ff;
      w_ch  = ch_ff;
      c_inc = (COL_W+1)'(cur_col_ff) + (COL_W+1)'(1);
      priority if (ch_ff == CH_NEWLINE) begin
         n_col  = '0;
         n_line = cur_line_ff + (ROW_W+1)'(1);
      end else if (ch_ff == CH_RETURN) begin
         n_col = '0;
      end else if (ch_ff == CH_BACKSPACE) begin
         if (cur_col_ff != '0) begin
            n_col = cur_col_ff - COL_W'(1);
            w_col = cur_col_ff - COL_W'(1);
            w_ch  = CH_SPACE;
            w_en  = 1'b1;
         end
      end else begin
         w_en = 1'b1;
         if (CW'(c_inc) >= CW'(cols_eff)) begin
            n_col  = '0;
            n_line = cur_line_ff + (ROW_W+1)'(1);
         end else begin
            n_col = COL_W'(c_inc);
         end
      end
      w_ok  = w_en && (CW'(w_col) < CW'(cols_eff)) && (CW'(cur_line_ff) < CW'(rows_eff));
      w_row = ROW_W'(cur_line_ff);
   end

   // read cell: locate the visible row in history or on screen
   always_comb begin
      rd_out  = (CW'(rcol_ff) >= CW'(cols_eff)) || (CW'(rrow_ff) >= CW'(rows_eff));
      pos     = PW'(count_ff) + PW'(rrow_ff) - PW'(view_ff);
      in_hist = pos < PW'(count_ff);
      slot_r  = PW'(head_ff) + pos;
      if (slot_r >= PW'(HISTORY_ROWS)) slot_r = slot_r - PW'(HISTORY_ROWS);
      spos    = pos - PW'(count_ff);
      s_far   = spos >= PW'(MAX_ROWS);
   end

   always_comb begin
      vsum = $signed(SW'(view_ff)) + SW'(delta_ff);
      if (vsum < 0) view_clamp = '0;
      else if (vsum > $signed(SW'(count_ff))) view_clamp = count_ff;
      else view_clamp = CNT_W'(vsum);
   end

   always_comb begin
      slot_s = (CNT_W+1)'(head_ff) + (CNT_W+1)'(count_ff);
      if (slot_s >= (CNT_W+1)'(HISTORY_ROWS)) slot_s = slot_s - (CNT_W+1)'(HISTORY_ROWS);
      save_slot = HEAD_W'(slot_s);
      head_inc  = (HEAD_W+1)'(head_ff) + (HEAD_W+1)'(1);
      if (CW'(count_ff) >= CW'(HISTORY_ROWS)) begin
         count_new = count_ff;
         head_new  = (head_inc == (HEAD_W+1)'(HISTORY_ROWS)) ? '0 : HEAD_W'(head_inc);
      end else begin
         count_new = count_ff + CNT_W'(1);
         head_new  = head_ff;
      end
   end

   assign sweep_last = pend_ff && (wcol_ff == COL_W'(MAX_COLS - 1));
   assign mrow_nxt   = mrow_ff + ROW_W'(1);
   assign move_last  = (CW'(mrow_ff) + CW'(1)) == CW'(rows_eff);
   assign nxt_ok     = row_valid_ff[mrow_nxt];
   assign sweep_on   = cmd.save || (cmd.move && !move_last && nxt_ok);

   always_comb begin
      scr_re   = 1'b0;
      scr_rrow = mrow_nxt;
      scr_rcol = cnt_ff[COL_W-1:0];
      if (cmd.exec && is_read) begin
         scr_re   = 1'b1;
         scr_rrow = ROW_W'(spos);
         scr_rcol = COL_W'(rcol_ff);
      end else if (sweep_on) begin
         scr_re   = cnt_ff < (COL_W+1)'(MAX_COLS);
         scr_rrow = cmd.save ? '0 : mrow_nxt;
      end
   end

   always_comb begin
      scr_we    = 1'b0;
      scr_wrow  = w_row;
      scr_wcol  = w_col;
      scr_wdata = w_ch;
      if (cmd.exec && is_put) begin
         scr_we = w_ok && row_valid_ff[w_row];
      end else if (cmd.fill) begin
         scr_we    = 1'b1;
         scr_wrow  = frow_ff;
         scr_wcol  = cnt_ff[COL_W-1:0];
         scr_wdata = (cnt_ff[COL_W-1:0] == fcol_ff) ? fch_ff : CH_SPACE;
      end else if (cmd.move && !move_last && nxt_ok) begin
         scr_we    = pend_ff;
         scr_wrow  = mrow_ff;
         scr_wcol  = wcol_ff;
         scr_wdata = scr_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (scr_we) screen_mem[{scr_wrow, scr_wcol}] <= scr_wdata;
      if (scr_re) begin
         scr_rd_ff    <= screen_mem[{scr_rrow, scr_rcol}];
         scr_rd_ok_ff <= row_valid_ff[scr_rrow];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.save && pend_ff)
         hist_mem[{save_slot, wcol_ff}] <= scr_rd_ok_ff ? scr_rd_ff : CH_SPACE;
      if (cmd.exec && is_read)
         hist_rd_ff <= hist_mem[{HEAD_W'(slot_r), COL_W'(rcol_ff)}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_cfg_ff <= COLS_RESET;
         rows_cfg_ff <= ROWS_RESET;
      end else if (csr_wr) begin
         unique case (reg_index_type'(csr_index))
            REG_COLUMNS: cols_cfg_ff <= csr_data;
            REG_ROWS:    rows_cfg_ff <= csr_data[6:0];
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff   <= cmd_code_type'(in_command);
         ch_ff    <= in_char_code;
         delta_ff <= in_scroll_delta;
         rcol_ff  <= in_read_col;
         rrow_ff  <= in_read_row;
      end
      if (cmd.exec && is_put) begin
         frow_ff <= w_row;
         fcol_ff <= w_col;
         fch_ff  <= w_ch;
      end
      if (cmd.exec && is_read) begin
         if (rd_out) rd_src_ff <= SRC_SPACE;
         else if (in_hist) rd_src_ff <= SRC_HIST;
         else if (s_far) rd_src_ff <= SRC_SPACE;
         else rd_src_ff <= SRC_SCREEN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff   <= '0;
         cur_line_ff  <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         view_ff      <= '0;
         row_valid_ff <= '0;
         scrolled_ff  <= 1'b0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         wcol_ff      <= '0;
         mrow_ff      <= '0;
      end else begin
         if (cmd.load) begin
            scrolled_ff <= 1'b0;
            cnt_ff      <= '0;
            pend_ff     <= 1'b0;
         end
         if (cmd.exec) begin
            unique case (cmd_ff)
               CMD_PUT: begin
                  cur_col_ff  <= n_col;
                  cur_line_ff <= n_line;
               end
               CMD_VIEW: view_ff <= view_clamp;
               CMD_CLEAR: begin
                  row_valid_ff <= '0;
                  head_ff      <= '0;
                  count_ff     <= '0;
                  view_ff      <= '0;
                  cur_col_ff   <= '0;
                  cur_line_ff  <= '0;
               end
               CMD_READ: ;
               default: ;
            endcase
         end
         if (cmd.fill) begin
            if (cnt_ff[COL_W-1:0] == COL_W'(MAX_COLS - 1)) begin
               row_valid_ff[frow_ff] <= 1'b1;
               cnt_ff <= '0;
            end else begin
               cnt_ff <= cnt_ff + (COL_W+1)'(1);
            end
         end
         if (sweep_on) begin
            if (cnt_ff < (COL_W+1)'(MAX_COLS)) begin
               cnt_ff  <= cnt_ff + (COL_W+1)'(1);
               pend_ff <= 1'b1;
               wcol_ff <= cnt_ff[COL_W-1:0];
            end else begin
               pend_ff <= 1'b0;
            end
            if (sweep_last) begin
               cnt_ff  <= '0;
               pend_ff <= 1'b0;
            end
         end
         if (cmd.save && sweep_last) begin
            head_ff  <= head_new;
            count_ff <= count_new;
            if (view_ff != '0 && view_ff < count_new) view_ff <= view_ff + CNT_W'(1);
            mrow_ff  <= '0;
         end
         if (cmd.move) begin
            if (move_last) begin
               row_valid_ff[mrow_ff] <= 1'b0;
               cur_line_ff <= cur_line_ff - (ROW_W+1)'(1);
               scrolled_ff <= 1'b1;
            end else if (!nxt_ok) begin
               row_valid_ff[mrow_ff] <= 1'b0;
               mrow_ff <= mrow_nxt;
            end else if (sweep_last) begin
               row_valid_ff[mrow_ff] <= 1'b1;
               mrow_ff <= mrow_nxt;
            end
         end
      end
   end

   always_comb begin
      if (!is_read) cell_val = 8'h00;
      else if (rd_src_ff == SRC_HIST) cell_val = hist_rd_ff;
      else if (rd_src_ff == SRC_SCREEN) cell_val = scr_rd_ok_ff ? scr_rd_ff : CH_SPACE;
      else cell_val = CH_SPACE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_cell_ff <= cell_val;
         rsp_col_ff  <= 7'(cur_col_ff);
         rsp_row_ff  <= 6'(cur_line_ff);
         rsp_view_ff <= 9'(view_ff);
         rsp_hist_ff <= 9'(count_ff);
         rsp_scr_ff  <= scrolled_ff;
      end
   end

   assign rsp_tvalid            = rsp_valid_ff;
   assign out_cell_char         = rsp_cell_ff;
   assign out_cursor_col        = rsp_col_ff;
   assign out_cursor_row        = rsp_row_ff;
   assign out_view_offset       = rsp_view_ff;
   assign out_history_rows_held = rsp_hist_ff;
   assign out_scrolled          = rsp_scr_ff;

   assign stat.is_put      = is_put;
   assign stat.fill_needed = is_put && w_ok && !row_valid_ff[w_row];
   assign stat.fill_last   = cnt_ff[COL_W-1:0] == COL_W'(MAX_COLS - 1);
   assign stat.line_over   = CW'(cur_line_ff) >= CW'(rows_eff);
   assign stat.save_last   = sweep_last;
   assign stat.move_last   = move_last;
   assign stat.out_free    = !rsp_valid_ff || rsp_tready;

   a_view_bound: assert property (@(posedge clock) disable iff (reset)
      view_ff <= count_ff)
      else $error("view offset beyond rows held");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CW'(count_ff) <= CW'(HISTORY_ROWS))
      else $error("ring count overflow");

   a_head_move: assert property (@(posedge clock) disable iff (reset)
      (head_ff != $past(head_ff)) |-> ($past(cmd.save) || $past(cmd.exec)))
      else $error("ring head moved outside a save or clear");

endmodule

### rtl/text_console_scrollback_engine.sv
// Top level of the text console scrollback engine.
// Depends on tcse_pkg, tcse_ctrl and tcse_datapath.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  req_tdata  (command, char, delta, col, row)
//   rsp      out  rsp_tvalid/rsp_tready  rsp_tdata  (cell, cursor, view, held, scrolled)
//   csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// Commands other than put pass through accept, execute and result states; a put adds a check state.
// A put into a blank row adds a row fill before the check.
// Each scroll adds a save of the top row to history and a copy of the screen rows up by one,
// with at most one screen read and one memory write per cycle.
// Reset is synchronous; screen rows start blank via per-row valid bits.
// One transaction is in flight; a finished result waits in the output register.
module text_console_scrollback_engine import tcse_pkg::*; #(
   parameter int MAX_COLS     = 128,
   parameter int MAX_ROWS     = 64,
   parameter int HISTORY_ROWS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] command, [9:2] char_code, [19:10] scroll_delta,
   // [26:20] read_col, [32:27] read_row, [39:33] zero
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] cell_char, [14:8] cursor_col, [20:15] cursor_row,
   // [29:21] view_offset, [38:30] history_rows_held, [39] scrolled
   output logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_data
);

   tcse_cmd_type  cmd;
   tcse_stat_type stat;
   logic [7:0]    cell_char;
   logic [6:0]    cursor_col;
   logic [5:0]    cursor_row;
   logic [8:0]    view_offset;
   logic [8:0]    history_rows_held;
   logic          scrolled;

   assign csr_ready = 1'b1;

   tcse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tcse_datapath #(
      .MAX_COLS     (MAX_COLS),
      .MAX_ROWS     (MAX_ROWS),
      .HISTORY_ROWS (HISTORY_ROWS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .csr_wr                (csr_valid && csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .in_command            (req_tdata[1:0]),
      .in_char_code          (req_tdata[9:2]),
      .in_scroll_delta       ($signed(req_tdata[19:10])),
      .in_read_col           (req_tdata[26:20]),
      .in_read_row           (req_tdata[32:27]),
      .rsp_tready            (rsp_tready),
      .rsp_tvalid            (rsp_tvalid),
      .out_cell_char         (cell_char),
      .out_cursor_col        (cursor_col),
      .out_cursor_row        (cursor_row),
      .out_view_offset       (view_offset),
      .out_history_rows_held (history_rows_held),
      .out_scrolled          (scrolled)
   );

   assign rsp_tdata = {scrolled, history_rows_held, view_offset,
                       cursor_row, cursor_col, cell_char};

endmodule
